// File: hw/rtl/ssr_pkg.sv
// Shared types, constants and helpers for the stream search-and-replace block.
// No dependencies; used by every file under hw/rtl.
package ssr_pkg;

    localparam int MAX_PATTERN = 8;
    localparam int BYTE_W      = 8;
    localparam int WORD_W      = MAX_PATTERN * BYTE_W;
    localparam int LEN_W       = 4;
    localparam int IDX_W       = $clog2(MAX_PATTERN);
    localparam int CFG_IDX_W   = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEARCH_PATTERN     = 2'd0,
        CFG_SEARCH_LENGTH      = 2'd1,
        CFG_REPLACEMENT_TEXT   = 2'd2,
        CFG_REPLACEMENT_LENGTH = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SEARCH,
        ST_EMIT,
        ST_MARK
    } t_state;

    typedef enum logic {
        SRC_HELD,
        SRC_REPL
    } t_src;

    // candidate test: held prefix length and candidate suffix length
    typedef struct packed {
        logic [IDX_W-1:0] held;
        logic [IDX_W-1:0] cand;
    } t_cand_req;

    function automatic logic [BYTE_W-1:0] byte_of(input logic [WORD_W-1:0] word,
                                                  input logic [IDX_W-1:0]  i);
        return word[BYTE_W*i +: BYTE_W];
    endfunction

endpackage

// File: hw/rtl/stream_search_and_replace.sv
// Stream search-and-replace: rewrites every leftmost, non-overlapping match of the pattern
// with the replacement text. Depends on ssr_pkg and ssr_cand_cmp.
//
// One byte is taken, then the block is busy: it tests the byte against the next pattern
// byte, then on a mismatch tries each fallback candidate in turn (at most pattern length
// minus one) through the shared candidate comparator, then emits each output byte (up to
// eight) or the empty end marker, each waiting on m_axis_tready. The output register lets
// the next byte be taken while the last result is still waiting. Configuration must be
// written only while the block is idle; the block itself does not enforce this.
module stream_search_and_replace (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [ssr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ssr_pkg::WORD_W-1:0]    i_cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [ssr_pkg::BYTE_W-1:0]    s_axis_tdata,   // [7:0] in_byte
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [ssr_pkg::BYTE_W-1:0]    m_axis_tdata,   // [7:0] out_byte
    output logic                          m_axis_tuser,   // [0] byte_valid
    output logic                          m_axis_tlast
);

    ssr_pkg::t_state                r_state, n_state;
    logic [ssr_pkg::WORD_W-1:0]     r_pattern, r_repl;
    logic [ssr_pkg::LEN_W-1:0]      r_slen, r_rlen;
    logic [ssr_pkg::IDX_W-1:0]      r_matched, n_matched;
    logic [ssr_pkg::BYTE_W-1:0]     r_byte;
    logic                           r_last;
    logic [ssr_pkg::IDX_W-1:0]      r_held, n_held;
    logic [ssr_pkg::IDX_W-1:0]      r_cand, n_cand;
    ssr_pkg::t_src                  r_src, n_src;
    logic [ssr_pkg::LEN_W-1:0]      r_cnt, n_cnt;
    logic [ssr_pkg::IDX_W-1:0]      r_idx, n_idx;
    logic                           r_out_valid, n_out_valid;
    logic [ssr_pkg::BYTE_W-1:0]     r_out_byte, n_out_byte;
    logic                           r_out_bvalid, n_out_bvalid;
    logic                           r_out_last, n_out_last;

    logic [ssr_pkg::LEN_W-1:0]      pat_len, rep_len, nxt;
    logic [ssr_pkg::IDX_W-1:0]      len_m1;
    logic                           in_acc, out_free, hit, cmp_hit;
    logic [ssr_pkg::BYTE_W-1:0]     emit_byte;
    ssr_pkg::t_cand_req             cand_req;

    always_comb begin
        if (r_slen == '0) begin
            pat_len = ssr_pkg::LEN_W'(1);
        end else if (r_slen > ssr_pkg::LEN_W'(ssr_pkg::MAX_PATTERN)) begin
            pat_len = ssr_pkg::LEN_W'(ssr_pkg::MAX_PATTERN);
        end else begin
            pat_len = r_slen;
        end
        if (r_rlen > ssr_pkg::LEN_W'(ssr_pkg::MAX_PATTERN)) begin
            rep_len = ssr_pkg::LEN_W'(ssr_pkg::MAX_PATTERN);
        end else begin
            rep_len = r_rlen;
        end
        len_m1 = ssr_pkg::IDX_W'(pat_len - ssr_pkg::LEN_W'(1));
    end

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;
    assign hit      = (r_byte == ssr_pkg::byte_of(r_pattern, r_held));
    assign nxt      = {1'b0, r_held} + ssr_pkg::LEN_W'(1);

    assign cand_req.held = r_held;
    assign cand_req.cand = r_cand;

    ssr_cand_cmp u_cand_cmp (
        .i_pattern (r_pattern),
        .i_byte    (r_byte),
        .i_req     (cand_req),
        .o_hit     (cmp_hit)
    );

    always_comb begin
        if (r_src == ssr_pkg::SRC_REPL) begin
            emit_byte = ssr_pkg::byte_of(r_repl, r_idx);
        end else if (r_idx < r_held) begin
            emit_byte = ssr_pkg::byte_of(r_pattern, r_idx);
        end else begin
            emit_byte = r_byte;
        end
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_slen    <= ssr_pkg::LEN_W'(1);
            r_repl    <= '0;
            r_rlen    <= '0;
        end else if (i_cfg_wr_en) begin
            case (ssr_pkg::t_cfg_idx'(i_cfg_index))
                ssr_pkg::CFG_SEARCH_PATTERN:     r_pattern <= i_cfg_wdata;
                ssr_pkg::CFG_SEARCH_LENGTH:      r_slen    <= i_cfg_wdata[ssr_pkg::LEN_W-1:0];
                ssr_pkg::CFG_REPLACEMENT_TEXT:   r_repl    <= i_cfg_wdata;
                ssr_pkg::CFG_REPLACEMENT_LENGTH: r_rlen    <= i_cfg_wdata[ssr_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ssr_pkg::ST_IDLE;
            r_matched   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_matched   <= n_matched;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_byte <= s_axis_tdata;
            r_last <= s_axis_tlast;
        end
        r_held       <= n_held;
        r_cand       <= n_cand;
        r_src        <= n_src;
        r_cnt        <= n_cnt;
        r_idx        <= n_idx;
        r_out_byte   <= n_out_byte;
        r_out_bvalid <= n_out_bvalid;
        r_out_last   <= n_out_last;
    end

    always_comb begin
        n_state      = r_state;
        n_matched    = r_matched;
        n_held       = r_held;
        n_cand       = r_cand;
        n_src        = r_src;
        n_cnt        = r_cnt;
        n_idx        = r_idx;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_byte   = r_out_byte;
        n_out_bvalid = r_out_bvalid;
        n_out_last   = r_out_last;
        s_axis_tready = 1'b0;

        case (r_state)
            ssr_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (in_acc) begin
                    n_held  = (r_matched > len_m1) ? len_m1 : r_matched;
                    n_state = ssr_pkg::ST_EVAL;
                end
            end
            ssr_pkg::ST_EVAL: begin
                n_idx = '0;
                n_src = ssr_pkg::SRC_HELD;
                n_cnt = '0;
                n_matched = '0;
                if (hit) begin
                    if (nxt == pat_len) begin
                        n_src = ssr_pkg::SRC_REPL;
                        n_cnt = rep_len;
                    end else if (r_last) begin
                        n_cnt = nxt;
                    end else begin
                        n_matched = r_held + ssr_pkg::IDX_W'(1);
                    end
                end else if (r_last || r_held == '0) begin
                    n_cnt = nxt;
                end else begin
                    n_cand = r_held;
                end

                if (!hit && !r_last && r_held != '0) begin
                    n_state = ssr_pkg::ST_SEARCH;
                end else if (n_cnt != '0) begin
                    n_state = ssr_pkg::ST_EMIT;
                end else if (r_last) begin
                    n_state = ssr_pkg::ST_MARK;
                end else begin
                    n_state = ssr_pkg::ST_IDLE;
                end
            end
            ssr_pkg::ST_SEARCH: begin
                if (cmp_hit) begin
                    n_matched = r_cand;
                    n_cnt     = nxt - {1'b0, r_cand};
                    n_state   = ssr_pkg::ST_EMIT;
                end else if (r_cand == ssr_pkg::IDX_W'(1)) begin
                    n_matched = '0;
                    n_cnt     = nxt;
                    n_state   = ssr_pkg::ST_EMIT;
                end else begin
                    n_cand = r_cand - ssr_pkg::IDX_W'(1);
                end
            end
            ssr_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_byte   = emit_byte;
                    n_out_bvalid = 1'b1;
                    n_out_last   = 1'b0;
                    n_idx        = r_idx + ssr_pkg::IDX_W'(1);
                    if (r_idx == ssr_pkg::IDX_W'(r_cnt - ssr_pkg::LEN_W'(1))) begin
                        n_out_last = r_last;
                        n_state    = ssr_pkg::ST_IDLE;
                    end
                end
            end
            ssr_pkg::ST_MARK: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_byte   = '0;
                    n_out_bvalid = 1'b0;
                    n_out_last   = 1'b1;
                    n_state      = ssr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ssr_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tuser  = r_out_bvalid;
    assign m_axis_tlast  = r_out_last;

endmodule

// File: hw/rtl/ssr_cand_cmp.sv
// Candidate compare unit: tests whether held prefix plus new byte ends in a
// pattern prefix of the candidate length. Depends on ssr_pkg.
module ssr_cand_cmp (
    input  logic [ssr_pkg::WORD_W-1:0] i_pattern,
    input  logic [ssr_pkg::BYTE_W-1:0] i_byte,
    input  ssr_pkg::t_cand_req         i_req,
    output logic                       o_hit
);

    logic [ssr_pkg::IDX_W-1:0] off;
    logic [ssr_pkg::IDX_W-1:0] cand_m1;

    always_comb begin
        off     = i_req.held - i_req.cand + ssr_pkg::IDX_W'(1);
        cand_m1 = i_req.cand - ssr_pkg::IDX_W'(1);
        o_hit   = (ssr_pkg::byte_of(i_pattern, cand_m1) == i_byte);
        for (int i = 0; i < ssr_pkg::MAX_PATTERN - 1; i++) begin
            if (ssr_pkg::IDX_W'(i) < cand_m1) begin
                if (ssr_pkg::byte_of(i_pattern, off + ssr_pkg::IDX_W'(i)) !=
                    ssr_pkg::byte_of(i_pattern, ssr_pkg::IDX_W'(i))) begin
                    o_hit = 1'b0;
                end
            end
        end
    end

endmodule

// File: hw/rtl/ssr_checker.sv
// Port-level checker for stream_search_and_replace, bound to the top level.
// Depends on ssr_pkg for widths.
module ssr_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       s_axis_tvalid,
    input logic                       s_axis_tready,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [ssr_pkg::BYTE_W-1:0] m_axis_tdata,
    input logic                       m_axis_tuser,
    input logic                       m_axis_tlast
);

    // the empty end marker is always the final item and carries a zero byte
    a_marker_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && m_axis_tdata == '0)
        else $error("empty marker without last or with data");

    // one item at a time: busy in the cycle after an input is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while busy");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled output item changed");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind stream_search_and_replace ssr_checker u_ssr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
